// File: rtl/core/esh_pkg.sv
`default_nettype none

package esh_pkg;

    // Axis configuration of the machine
    localparam int AXIS_COUNT = 3;
    localparam int ZOOM_INDEX = 2;
    localparam int AXIS_W     = 2;
    localparam int MASK_W     = 3;

    localparam int SPEED_W    = 16;
    localparam int DIST_W     = 20;
    localparam int POS_W      = 32;
    localparam int TIME_W     = 32;
    localparam int VEL_W      = SPEED_W + 1;
    localparam int CODE_W     = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FAST_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_SPEED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_DIST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_VALUE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENDSTOP_MASK = 3'd5;

    // Opcodes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;

    // Reported state codes
    localparam logic [CODE_W-1:0] CODE_IDLE = 3'd0;
    localparam logic [CODE_W-1:0] CODE_FAST = 3'd1;
    localparam logic [CODE_W-1:0] CODE_BACK = 3'd2;
    localparam logic [CODE_W-1:0] CODE_SLOW = 3'd3;
    localparam logic [CODE_W-1:0] CODE_DONE = 3'd4;
    localparam logic [CODE_W-1:0] CODE_ERR  = 3'd5;

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_FAST = 6'b000010,
        MODE_BACK = 6'b000100,
        MODE_SLOW = 6'b001000,
        MODE_DONE = 6'b010000,
        MODE_ERR  = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [SPEED_W-1:0]       fast_speed;
        logic [SPEED_W-1:0]       slow_speed;
        logic [DIST_W-1:0]        backoff_len;
        logic signed [POS_W-1:0]  home_value;
        logic [TIME_W-1:0]        timeout_limit;
        logic [MASK_W-1:0]        endstop_mask;
    } cfg_t;

    function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
        logic [CODE_W-1:0] c;
        case (m)
            MODE_IDLE: c = CODE_IDLE;
            MODE_FAST: c = CODE_FAST;
            MODE_BACK: c = CODE_BACK;
            MODE_SLOW: c = CODE_SLOW;
            MODE_DONE: c = CODE_DONE;
            MODE_ERR:  c = CODE_ERR;
            default:   c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/esh_cfg_regs.sv
`default_nettype none

module esh_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [esh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [esh_pkg::CFG_DATA_W-1:0]   cfg_data,
    output esh_pkg::cfg_t                         cfg
);

    esh_pkg::cfg_t cfg_reg;
    esh_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                esh_pkg::REG_FAST_SPEED:
                    cfg_next.fast_speed = cfg_data[esh_pkg::SPEED_W-1:0];
                esh_pkg::REG_SLOW_SPEED:
                    cfg_next.slow_speed = cfg_data[esh_pkg::SPEED_W-1:0];
                esh_pkg::REG_BACKOFF_DIST:
                    cfg_next.backoff_len = cfg_data[esh_pkg::DIST_W-1:0];
                esh_pkg::REG_HOME_VALUE:
                    cfg_next.home_value = $signed(cfg_data[esh_pkg::POS_W-1:0]);
                esh_pkg::REG_TIMEOUT:
                    cfg_next.timeout_limit = cfg_data[esh_pkg::TIME_W-1:0];
                esh_pkg::REG_ENDSTOP_MASK:
                    cfg_next.endstop_mask = cfg_data[esh_pkg::MASK_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_speed       <= 16'd1000;
            cfg_reg.slow_speed       <= 16'd200;
            cfg_reg.backoff_len      <= 20'd500;
            cfg_reg.home_value       <= 32'sd0;
            cfg_reg.timeout_limit    <= 32'd30000;
            cfg_reg.endstop_mask     <= 3'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/core/endstop_homing_sequencer_unit.sv
// Path: a transaction goes to the input register, then, once the result stage
// is free or draining, to the result register. Throughput: one transaction per
// cycle while out_ready does not stall a full result stage; each is resolved by
// a single pass of compare and add logic between the input and result registers.
// Reset (rst_n, asynchronous, active low): sequencer idle, manual mode off,
// both stages empty, configuration back to its default values.
`default_nettype none

module endstop_homing_sequencer_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [esh_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [esh_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [1:0]                           opcode,
    input  wire logic [esh_pkg::AXIS_W-1:0]           axis_sel,
    input  wire logic [esh_pkg::TIME_W-1:0]           now_ms,
    input  wire logic                                 endstop_hit,
    input  wire logic signed [esh_pkg::POS_W-1:0]     axis_position,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      ok,
    output logic [esh_pkg::CODE_W-1:0]                state_code,
    output logic                                      active,
    output logic                                      vel_valid,
    output logic signed [esh_pkg::VEL_W-1:0]          velocity_cmd,
    output logic [esh_pkg::AXIS_W-1:0]                cmd_axis,
    output logic                                      set_home,
    output logic                                      manual_mode
);

    esh_pkg::cfg_t cfg;

    // Input stage
    logic                              s1_valid_reg, s1_valid_next;
    logic [1:0]                        s1_op_reg;
    logic [esh_pkg::AXIS_W-1:0]        s1_axis_reg;
    logic [esh_pkg::TIME_W-1:0]        s1_now_reg;
    logic                              s1_hit_reg;
    logic signed [esh_pkg::POS_W-1:0]  s1_pos_reg;

    // Sequencer state
    esh_pkg::mode_t                    mode_reg, mode_next;
    logic [esh_pkg::AXIS_W-1:0]        axis_reg, axis_next;
    logic [esh_pkg::TIME_W-1:0]        start_reg, start_next;
    logic signed [esh_pkg::VEL_W-1:0]  vel_reg, vel_next;
    logic signed [esh_pkg::POS_W-1:0]  origin_reg, origin_next;
    logic                              manual_reg, manual_next;

    // Result stage
    logic                              out_valid_reg, out_valid_next;
    logic                              ok_reg, ok_next;
    logic [esh_pkg::CODE_W-1:0]        code_reg;
    logic                              active_reg;
    logic                              vv_reg, vv_next;
    logic signed [esh_pkg::VEL_W-1:0]  vcmd_reg, vcmd_next;
    logic                              sh_reg, sh_next;

    logic                              take_in;
    logic                              advance;
    logic [esh_pkg::MASK_W:0]          mask_ext;
    logic                              axis_ok;
    logic [esh_pkg::TIME_W-1:0]        elapsed;
    logic                              timed_out;
    logic signed [esh_pkg::POS_W:0]    backoff_end;
    logic                              backoff_done;

    esh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;
    assign take_in  = in_valid && in_ready;

    assign s1_valid_next  = take_in ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Axis qualification; axis codes past the mask read as no endstop
    assign mask_ext = {1'b0, cfg.endstop_mask};
    assign axis_ok  = ({1'b0, s1_axis_reg} < 3'(esh_pkg::AXIS_COUNT))
                   && ({1'b0, s1_axis_reg} != 3'(esh_pkg::ZOOM_INDEX))
                   && ({1'b0, s1_axis_reg} < 3'(esh_pkg::MASK_W))
                   && mask_ext[s1_axis_reg];

    assign elapsed   = s1_now_reg - start_reg;
    assign timed_out = (cfg.timeout_limit != '0) && (elapsed > cfg.timeout_limit);

    // Backoff end at 33 bits so the origin plus distance never wraps
    assign backoff_end  = {origin_reg[esh_pkg::POS_W-1], origin_reg}
                        + $signed({13'd0, cfg.backoff_len});
    assign backoff_done = $signed({s1_pos_reg[esh_pkg::POS_W-1], s1_pos_reg})
                          >= backoff_end;

    always_comb
    begin
        mode_next   = mode_reg;
        axis_next   = axis_reg;
        start_next  = start_reg;
        vel_next    = vel_reg;
        origin_next = origin_reg;
        manual_next = manual_reg;
        ok_next     = 1'b0;
        vv_next     = 1'b0;
        vcmd_next   = '0;
        sh_next     = 1'b0;

        case (s1_op_reg)
            esh_pkg::OP_START:
            begin
                if (axis_ok && mode_reg == esh_pkg::MODE_IDLE)
                begin
                    axis_next   = s1_axis_reg;
                    mode_next   = esh_pkg::MODE_FAST;
                    vel_next    = -$signed({1'b0, cfg.fast_speed});
                    start_next  = s1_now_reg;
                    manual_next = 1'b1;
                    ok_next     = 1'b1;
                end
            end
            esh_pkg::OP_UPDATE:
            begin
                if (mode_reg == esh_pkg::MODE_IDLE || mode_reg == esh_pkg::MODE_DONE)
                begin
                    ok_next = 1'b1;
                end
                else if (mode_reg == esh_pkg::MODE_ERR)
                begin
                    ok_next = 1'b0;
                end
                else if (timed_out)
                begin
                    mode_next = esh_pkg::MODE_ERR;
                end
                else if (mode_reg == esh_pkg::MODE_FAST)
                begin
                    if (s1_hit_reg)
                    begin
                        // first hit: record where it happened and reverse
                        mode_next   = esh_pkg::MODE_BACK;
                        vel_next    = $signed({1'b0, cfg.fast_speed});
                        origin_next = s1_pos_reg;
                    end
                    else
                    begin
                        vv_next   = 1'b1;
                        vcmd_next = vel_reg;
                    end
                end
                else if (mode_reg == esh_pkg::MODE_BACK)
                begin
                    if (backoff_done)
                    begin
                        mode_next = esh_pkg::MODE_SLOW;
                        vel_next  = -$signed({1'b0, cfg.slow_speed});
                    end
                    else
                    begin
                        vv_next   = 1'b1;
                        vcmd_next = vel_reg;
                    end
                end
                else
                begin
                    vv_next = 1'b1;
                    if (s1_hit_reg)
                    begin
                        sh_next     = 1'b1;
                        manual_next = 1'b0;
                        mode_next   = esh_pkg::MODE_DONE;
                        ok_next     = 1'b1;
                    end
                    else
                    begin
                        vcmd_next = vel_reg;
                    end
                end
            end
            esh_pkg::OP_STOP:
            begin
                if (mode_reg != esh_pkg::MODE_IDLE && mode_reg != esh_pkg::MODE_DONE)
                begin
                    vv_next     = 1'b1;
                    manual_next = 1'b0;
                    mode_next   = esh_pkg::MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= esh_pkg::MODE_IDLE;
            axis_reg      <= '0;
            start_reg     <= '0;
            vel_reg       <= '0;
            origin_reg    <= '0;
            manual_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mode_reg   <= mode_next;
                axis_reg   <= axis_next;
                start_reg  <= start_next;
                vel_reg    <= vel_next;
                origin_reg <= origin_next;
                manual_reg <= manual_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_op_reg   <= opcode;
            s1_axis_reg <= axis_sel;
            s1_now_reg  <= now_ms;
            s1_hit_reg  <= endstop_hit;
            s1_pos_reg  <= axis_position;
        end
        if (advance)
        begin
            ok_reg     <= ok_next;
            code_reg   <= esh_pkg::mode_code(mode_next);
            active_reg <= (mode_next == esh_pkg::MODE_FAST)
                       || (mode_next == esh_pkg::MODE_BACK)
                       || (mode_next == esh_pkg::MODE_SLOW);
            vv_reg     <= vv_next;
            vcmd_reg   <= vcmd_next;
            sh_reg     <= sh_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign state_code   = code_reg;
    assign active       = active_reg;
    assign vel_valid    = vv_reg;
    assign velocity_cmd = vcmd_reg;
    assign cmd_axis     = axis_reg;
    assign set_home     = sh_reg;
    assign manual_mode  = manual_reg;

    a_home_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && set_home) |-> (state_code == esh_pkg::CODE_DONE && vel_valid
                                     && velocity_cmd == '0 && !manual_mode))
        else $error("set_home without completion");

    a_active_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (active == (state_code == esh_pkg::CODE_FAST
                                  || state_code == esh_pkg::CODE_BACK
                                  || state_code == esh_pkg::CODE_SLOW)))
        else $error("active disagrees with state code");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled with room in the pipeline");

    a_start_sets_manual: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_op_reg == esh_pkg::OP_START && ok_next)
            |=> (manual_reg && mode_reg == esh_pkg::MODE_FAST))
        else $error("accepted start did not enter fast approach");

    a_state_frozen_without_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(mode_reg) && $stable(manual_reg))
        else $error("sequencer state moved without a transaction");

endmodule

`default_nettype wire

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 4;

    typedef logic [1:0]                          op_t;
    typedef logic [esh_pkg::AXIS_W-1:0]          axis_t;
    typedef logic [esh_pkg::TIME_W-1:0]          ms_t;
    typedef logic [esh_pkg::POS_W-1:0]           pos_t;
    typedef logic [esh_pkg::SPEED_W-1:0]         speed_t;
    typedef logic [esh_pkg::DIST_W-1:0]          span_t;
    typedef logic [esh_pkg::MASK_W-1:0]          mask_t;
    typedef logic [esh_pkg::CFG_IDX_W-1:0]       idx_t;
    typedef logic [esh_pkg::CFG_DATA_W-1:0]      word_t;
    typedef logic [esh_pkg::CODE_W-1:0]          code_t;
    typedef logic [esh_pkg::VEL_W-1:0]           vel_t;

    // opcode value with no command behind it
    localparam op_t OP_SPARE = 2'd3;

    typedef struct packed {
        op_t               op;
        axis_t             axis;
        ms_t               now;
        logic              hit;
        pos_t              pos;
    } homing_cmd_t;

    typedef struct packed {
        logic              ok;
        code_t             code;
        logic              active;
        logic              vel_valid;
        vel_t              vel;
        axis_t             axis;
        logic              set_home;
        logic              manual;
    } homing_status_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    idx_t                    cfg_index = '0;
    word_t                   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    op_t                     opcode = '0;
    axis_t                   axis_sel = '0;
    ms_t                     now_ms = '0;
    logic                    endstop_hit = 1'b0;
    logic signed [esh_pkg::POS_W-1:0] axis_position = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    ok;
    code_t                   state_code;
    logic                    active;
    logic                    vel_valid;
    logic signed [esh_pkg::VEL_W-1:0] velocity_cmd;
    axis_t                   cmd_axis;
    logic                    set_home;
    logic                    manual_mode;

    // predicted sequencer state and live register copy
    esh_pkg::cfg_t           hcfg;
    code_t                   hm_mode;
    axis_t                   hm_axis;
    ms_t                     hm_start;
    vel_t                    hm_vel;
    logic signed [esh_pkg::POS_W-1:0] hm_origin;
    logic                    hm_manual;
    homing_status_t          status_q[$];

    logic                    tx_idle_en = 1'b1;
    logic                    rx_idle_en = 1'b1;
    logic                    allow_home = 1'b0;
    int                      hold_ask = 0;
    int                      hold_served = 0;
    int                      hold_left = 0;
    int                      quiet_cycles = 0;
    ms_t                     clock_ms = '0;

    int mismatches = 0;
    int sent = 0;
    int checked = 0;
    int configs = 0;
    int timeouts = 0;
    int homings = 0;

    endstop_homing_sequencer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .axis_sel     (axis_sel),
        .now_ms       (now_ms),
        .endstop_hit  (endstop_hit),
        .axis_position(axis_position),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ok           (ok),
        .state_code   (state_code),
        .active       (active),
        .vel_valid    (vel_valid),
        .velocity_cmd (velocity_cmd),
        .cmd_axis     (cmd_axis),
        .set_home     (set_home),
        .manual_mode  (manual_mode)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic homing_status_t homing_next(input homing_cmd_t c);
        homing_status_t          r;
        ms_t                     elapsed;
        logic signed [esh_pkg::POS_W+1:0] bound;
        r = '0;
        elapsed = c.now - hm_start;
        // backoff end is computed wide so it never wraps
        bound = hm_origin + $signed({14'd0, hcfg.backoff_len});
        case (c.op)
            esh_pkg::OP_START:
            begin
                if (c.axis < esh_pkg::AXIS_COUNT && c.axis != esh_pkg::ZOOM_INDEX
                    && hm_mode == esh_pkg::CODE_IDLE && hcfg.endstop_mask[c.axis])
                begin
                    hm_axis   = c.axis;
                    hm_mode   = esh_pkg::CODE_FAST;
                    hm_vel    = -{1'b0, hcfg.fast_speed};
                    hm_start  = c.now;
                    hm_manual = 1'b1;
                    r.ok      = 1'b1;
                end
            end
            esh_pkg::OP_UPDATE:
            begin
                if (hm_mode == esh_pkg::CODE_IDLE || hm_mode == esh_pkg::CODE_DONE)
                begin
                    r.ok = 1'b1;
                end
                else if (hm_mode == esh_pkg::CODE_ERR)
                begin
                    r.ok = 1'b0;
                end
                else if (hcfg.timeout_limit != 0 && elapsed > hcfg.timeout_limit)
                begin
                    hm_mode = esh_pkg::CODE_ERR;
                    timeouts++;
                end
                else if (hm_mode == esh_pkg::CODE_FAST)
                begin
                    if (c.hit)
                    begin
                        hm_mode   = esh_pkg::CODE_BACK;
                        hm_vel    = {1'b0, hcfg.fast_speed};
                        hm_origin = c.pos;
                    end
                    else
                    begin
                        r.vel_valid = 1'b1;
                        r.vel       = hm_vel;
                    end
                end
                else if (hm_mode == esh_pkg::CODE_BACK)
                begin
                    if ($signed(c.pos) >= bound)
                    begin
                        hm_mode = esh_pkg::CODE_SLOW;
                        hm_vel  = -{1'b0, hcfg.slow_speed};
                    end
                    else
                    begin
                        r.vel_valid = 1'b1;
                        r.vel       = hm_vel;
                    end
                end
                else if (c.hit)
                begin
                    r.set_home  = 1'b1;
                    r.vel_valid = 1'b1;
                    r.vel       = '0;
                    r.ok        = 1'b1;
                    hm_manual   = 1'b0;
                    hm_mode     = esh_pkg::CODE_DONE;
                    homings++;
                end
                else
                begin
                    r.vel_valid = 1'b1;
                    r.vel       = hm_vel;
                end
            end
            esh_pkg::OP_STOP:
            begin
                if (hm_mode != esh_pkg::CODE_IDLE && hm_mode != esh_pkg::CODE_DONE)
                begin
                    r.vel_valid = 1'b1;
                    r.vel       = '0;
                    hm_manual   = 1'b0;
                    hm_mode     = esh_pkg::CODE_IDLE;
                end
            end
            default: ;
        endcase
        r.code   = hm_mode;
        r.active = (hm_mode == esh_pkg::CODE_FAST || hm_mode == esh_pkg::CODE_BACK
                    || hm_mode == esh_pkg::CODE_SLOW);
        r.axis   = hm_axis;
        r.manual = hm_manual;
        return r;
    endfunction

    function automatic void chk(input string name, input logic signed [32:0] want,
                                input logic signed [32:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic pos_t pos_at(input longint p);
        if (p > 64'sd2147483647)
            p = 64'sd2147483647;
        if (p < -64'sd2147483648)
            p = -64'sd2147483648;
        return p[esh_pkg::POS_W-1:0];
    endfunction

    function automatic ms_t tick_ms();
        clock_ms = clock_ms + $urandom_range(1, 40);
        return clock_ms;
    endfunction

    function automatic axis_t pick_axis();
        axis_t a;
        a = axis_t'($urandom_range(3));
        if ($urandom_range(7) != 0)
            a[1] = 1'b0;
        return a;
    endfunction

    function automatic speed_t pick_speed();
        case ($urandom_range(5))
            0: return speed_t'(1);
            1: return '1;
            default: return speed_t'($urandom_range(1, 65535));
        endcase
    endfunction

    // offer one command and hold it until the unit accepts it
    task automatic send_cmd(input op_t op, input axis_t axis, input ms_t now,
                            input logic hit, input pos_t pos);
        homing_cmd_t c;
        // keep random traffic from finishing the homing; only the last test may
        if (!allow_home && op == esh_pkg::OP_UPDATE && hm_mode == esh_pkg::CODE_SLOW)
            hit = 1'b0;
        c = {op, axis, now, hit, pos};
        if (tx_idle_en && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 31);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        axis_sel      <= axis;
        now_ms        <= now;
        endstop_hit   <= hit;
        axis_position <= pos;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        status_q.push_back(homing_next(c));
        sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input idx_t idx, input word_t val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            esh_pkg::REG_FAST_SPEED:   hcfg.fast_speed    = val[esh_pkg::SPEED_W-1:0];
            esh_pkg::REG_SLOW_SPEED:   hcfg.slow_speed    = val[esh_pkg::SPEED_W-1:0];
            esh_pkg::REG_BACKOFF_DIST: hcfg.backoff_len   = val[esh_pkg::DIST_W-1:0];
            esh_pkg::REG_HOME_VALUE:   hcfg.home_value    = val;
            esh_pkg::REG_TIMEOUT:      hcfg.timeout_limit = val;
            esh_pkg::REG_ENDSTOP_MASK: hcfg.endstop_mask  = val[esh_pkg::MASK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input speed_t fast, input speed_t slow, input span_t back_len,
                              input pos_t home, input ms_t tmo, input mask_t mask);
        write_reg(esh_pkg::REG_FAST_SPEED, word_t'(fast));
        write_reg(esh_pkg::REG_SLOW_SPEED, word_t'(slow));
        write_reg(esh_pkg::REG_BACKOFF_DIST, word_t'(back_len));
        write_reg(esh_pkg::REG_HOME_VALUE, home);
        write_reg(esh_pkg::REG_TIMEOUT, tmo);
        write_reg(esh_pkg::REG_ENDSTOP_MASK, word_t'(mask));
        configs++;
    endtask

    task automatic random_config();
        span_t back_len;
        ms_t   tmo;
        mask_t mask;
        case ($urandom_range(4))
            0: back_len = '0;
            1: back_len = '1;
            2: back_len = span_t'($urandom());
            default: back_len = span_t'($urandom_range(3000));
        endcase
        case ($urandom_range(4))
            0: tmo = '0;
            1: tmo = $urandom();
            2: tmo = '1;
            default: tmo = $urandom_range(100, 600);
        endcase
        mask = mask_t'($urandom_range(7));
        if (mask[1:0] == 2'b00 && $urandom_range(3) != 0)
            mask[0] = 1'b1;
        set_config(pick_speed(), pick_speed(), back_len, $urandom(), tmo, mask);
    endtask

    task automatic maybe_noise();
        if ($urandom_range(9) == 0)
            send_cmd(op_t'($urandom_range(3)), axis_t'($urandom()), $urandom(),
                     1'($urandom_range(1)), $urandom());
    endtask

    // one homing attempt: start, approach, first hit, backoff, slow approach, abort
    task automatic homing_run();
        pos_t   origin;
        longint base;
        clock_ms = $urandom();
        send_cmd(esh_pkg::OP_START, pick_axis(), clock_ms, 1'($urandom_range(1)), $urandom());
        if (hm_mode == esh_pkg::CODE_IDLE)
            return;
        repeat ($urandom_range(4))
        begin
            maybe_noise();
            send_cmd(esh_pkg::OP_UPDATE, axis_t'($urandom()), tick_ms(), 1'b0, $urandom());
        end
        origin = $urandom();
        base   = longint'($signed(origin));
        send_cmd(esh_pkg::OP_UPDATE, axis_t'($urandom()), tick_ms(), 1'b1, origin);
        repeat ($urandom_range(3))
        begin
            maybe_noise();
            send_cmd(esh_pkg::OP_UPDATE, axis_t'($urandom()), tick_ms(), 1'($urandom_range(1)),
                     pos_at(base - 1 + longint'($urandom_range(hcfg.backoff_len))));
        end
        send_cmd(esh_pkg::OP_UPDATE, axis_t'($urandom()), tick_ms(), 1'($urandom_range(1)),
                 pos_at(base + longint'(hcfg.backoff_len) + longint'($urandom_range(2))));
        repeat ($urandom_range(4))
        begin
            maybe_noise();
            send_cmd(esh_pkg::OP_UPDATE, axis_t'($urandom()), tick_ms(), 1'($urandom_range(1)),
                     $urandom());
        end
        if (hcfg.timeout_limit != 0 && $urandom_range(3) == 0)
        begin
            send_cmd(esh_pkg::OP_UPDATE, axis_t'($urandom()),
                     hm_start + hcfg.timeout_limit + $urandom_range(1, 3),
                     1'($urandom_range(1)), $urandom());
            send_cmd(esh_pkg::OP_UPDATE, axis_t'($urandom()), tick_ms(), 1'($urandom_range(1)),
                     $urandom());
            send_cmd(esh_pkg::OP_START, pick_axis(), tick_ms(), 1'($urandom_range(1)),
                     $urandom());
        end
        send_cmd(esh_pkg::OP_STOP, axis_t'($urandom()), $urandom(), 1'($urandom_range(1)),
                 $urandom());
    endtask

    task automatic test_idle_commands();
        send_cmd(esh_pkg::OP_UPDATE, 2'd0, 32'd0, 1'b1, 32'd0);
        send_cmd(esh_pkg::OP_STOP, 2'd3, '1, 1'b0, '1);
        send_cmd(OP_SPARE, 2'd1, 32'd7, 1'b1, 32'h8000_0000);
        send_cmd(esh_pkg::OP_START, axis_t'(esh_pkg::ZOOM_INDEX), 32'd1, 1'b0, 32'd0);
        send_cmd(esh_pkg::OP_START, 2'd3, 32'd2, 1'b0, 32'd0);
    endtask

    task automatic test_fast_backoff_timeout();
        ms_t t0;
        t0 = 32'hFFFF_FF00;
        send_cmd(esh_pkg::OP_START, 2'd0, t0, 1'b0, 32'd0);
        send_cmd(esh_pkg::OP_START, 2'd1, t0, 1'b0, 32'd0);
        // time wraps past zero without a timeout
        send_cmd(esh_pkg::OP_UPDATE, 2'd0, 32'h0000_0010, 1'b0, 32'd100);
        // first hit near the top of the position range: end lies beyond it
        send_cmd(esh_pkg::OP_UPDATE, 2'd0, 32'h0000_0020, 1'b1, 32'd2147483500);
        send_cmd(esh_pkg::OP_UPDATE, 2'd0, 32'h0000_0030, 1'b0, 32'h7FFF_FFFF);
        send_cmd(esh_pkg::OP_UPDATE, 2'd0, t0 + 32'd30000, 1'b0, 32'd0);
        send_cmd(esh_pkg::OP_UPDATE, 2'd0, t0 + 32'd30001, 1'b0, 32'd0);
        send_cmd(esh_pkg::OP_UPDATE, 2'd0, t0 + 32'd30002, 1'b0, 32'd0);
        send_cmd(esh_pkg::OP_START, 2'd0, 32'd5, 1'b0, 32'd0);
        send_cmd(esh_pkg::OP_STOP, 2'd0, 32'd6, 1'b0, 32'd0);
    endtask

    task automatic test_config_extremes();
        drain_results();
        set_config('1, '1, '0, 32'h8000_0000, '0, 3'b111);
        send_cmd(esh_pkg::OP_START, axis_t'(esh_pkg::ZOOM_INDEX), 32'd0, 1'b0, 32'd0);
        send_cmd(esh_pkg::OP_START, 2'd1, 32'd0, 1'b1, '1);
        // timeout disabled: a huge elapsed time is harmless
        send_cmd(esh_pkg::OP_UPDATE, 2'd2, 32'hFFFF_FFFF, 1'b0, 32'd12);
        send_cmd(esh_pkg::OP_UPDATE, 2'd1, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000);
        send_cmd(esh_pkg::OP_UPDATE, 2'd1, 32'd3, 1'b0, 32'h8000_0000);
        send_cmd(esh_pkg::OP_UPDATE, 2'd1, 32'd4, 1'b0, 32'h7FFF_FFFF);
        send_cmd(esh_pkg::OP_STOP, 2'd1, 32'd5, 1'b1, 32'd0);
        drain_results();
        set_config(16'd1, 16'd1, '1, 32'h7FFF_FFFF, '1, 3'b000);
        send_cmd(esh_pkg::OP_START, 2'd0, 32'd0, 1'b0, 32'd0);
    endtask

    task automatic test_random_homing(input int phases, input int runs);
        repeat (phases)
        begin
            drain_results();
            random_config();
            repeat (runs) homing_run();
        end
    endtask

    task automatic test_no_idle_stretch();
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        repeat (12) homing_run();
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
    endtask

    task automatic test_output_stall();
        hold_ask <= hold_ask + 1;
        repeat (3) homing_run();
    endtask

    task automatic test_homing_complete();
        drain_results();
        set_config(16'd1500, 16'd300, 20'd1000, $urandom(), '0, 3'b011);
        allow_home = 1'b1;
        send_cmd(esh_pkg::OP_START, 2'd1, 32'd5000, 1'b0, 32'd0);
        send_cmd(esh_pkg::OP_UPDATE, 2'd0, 32'd5010, 1'b0, 32'd4000);
        send_cmd(esh_pkg::OP_UPDATE, 2'd0, 32'd5020, 1'b1, -32'sd1000);
        send_cmd(esh_pkg::OP_UPDATE, 2'd0, 32'd5030, 1'b0, 32'd0);
        send_cmd(esh_pkg::OP_UPDATE, 2'd0, 32'd5040, 1'b0, 32'hFFFF_FF00);
        send_cmd(esh_pkg::OP_UPDATE, 2'd0, 32'd5050, 1'b1, 32'hFFFF_FF00);
        send_cmd(esh_pkg::OP_UPDATE, 2'd0, 32'd5060, 1'b1, 32'd0);
        send_cmd(esh_pkg::OP_START, 2'd0, 32'd5070, 1'b0, 32'd0);
        send_cmd(esh_pkg::OP_STOP, 2'd0, 32'd5080, 1'b0, 32'd0);
        // once complete the sequencer stays there; anything goes
        repeat (20)
            send_cmd(op_t'($urandom_range(3)), axis_t'($urandom()), $urandom(),
                     1'($urandom_range(1)), $urandom());
    endtask

    // receiver: random stalls, a quiet stretch, and one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_ask != hold_served)
        begin
            out_ready   <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_ask;
        end
        else if (!rx_idle_en)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 31);
    end

    always @(posedge clk)
    begin : status_check
        homing_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            checked++;
            if (status_q.size() == 0)
            begin
                $error("status result with no command outstanding");
                mismatches++;
            end
            else
            begin
                want = status_q.pop_front();
                chk("ok", 33'(want.ok), 33'(ok));
                chk("state_code", 33'(want.code), 33'(state_code));
                chk("active", 33'(want.active), 33'(active));
                chk("vel_valid", 33'(want.vel_valid), 33'(vel_valid));
                chk("velocity_cmd", 33'($signed(want.vel)), 33'(velocity_cmd));
                chk("cmd_axis", 33'(want.axis), 33'(cmd_axis));
                chk("set_home", 33'(want.set_home), 33'(set_home));
                chk("manual_mode", 33'(want.manual), 33'(manual_mode));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("endstop_homing_sequencer_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        hcfg.fast_speed       = 16'd1000;
        hcfg.slow_speed       = 16'd200;
        hcfg.backoff_len      = 20'd500;
        hcfg.home_value       = '0;
        hcfg.timeout_limit    = 32'd30000;
        hcfg.endstop_mask     = 3'b011;
        hm_mode   = esh_pkg::CODE_IDLE;
        hm_axis   = '0;
        hm_start  = '0;
        hm_vel    = '0;
        hm_origin = '0;
        hm_manual = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_commands();
        test_fast_backoff_timeout();
        test_config_extremes();
        test_random_homing(6, 34);
        test_no_idle_stretch();
        test_output_stall();
        test_homing_complete();
        drain_results();
        $display("Covered %0d commands, %0d status results, %0d register settings",
                 sent, checked, configs);
        $display("Homing runs ended by timeout: %0d, completed with set-home: %0d",
                 timeouts, homings);
        if (mismatches == 0)
            $display("endstop_homing_sequencer_unit verification clean");
        else
            $display("endstop_homing_sequencer_unit verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/esh_pkg.sv
rtl/core/esh_cfg_regs.sv
rtl/core/endstop_homing_sequencer_unit.sv
verif/tb.sv
